[rtl/core/sflf_pkg.sv]
// ----------------------------------------------------------------------------
// sflf_pkg
// Shared types and constants of the substring first/last finder.
// ----------------------------------------------------------------------------
package sflf_pkg;

	localparam int CFG_DATA_W  = 64;
	localparam int CFG_IDX_W   = 3;
	localparam int LEN_W       = 6;
	localparam int PAT_BYTES   = 32;
	localparam int PAT_IDX_W   = 5;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_PAT_LEN = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PAT_0_7 = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_PAT_8_15 = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_PAT_16_23 = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_PAT_24_31 = 3'd4;

	typedef struct packed {
		logic [7:0] text_char;
		logic       line_end;
	} in_t;

	typedef struct packed {
		logic       match_ends_here;
		logic       found_any;
		logic [7:0] leftmost_start;
		logic [7:0] rightmost_start;
		logic       line_overflow;
		logic       is_line_end;
	} out_t;

	typedef struct packed {
		logic [LEN_W-1:0]          pattern_length;
		logic [PAT_BYTES-1:0][7:0] pattern;
	} cfg_t;

endpackage

[rtl/core/sflf_cfg.sv]
// ----------------------------------------------------------------------------
// sflf_cfg
// Configuration registers: pattern length and the 32 pattern bytes.
// ----------------------------------------------------------------------------
module sflf_cfg (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [sflf_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [sflf_pkg::CFG_DATA_W-1:0]  cfg_data,
	output sflf_pkg::cfg_t                   cfg
);
	import sflf_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_PAT_LEN: begin
					cfg_q.pattern_length <= cfg_data[LEN_W-1:0];
				end
				CFG_PAT_0_7: begin
					cfg_q.pattern[7:0] <= cfg_data;
				end
				CFG_PAT_8_15: begin
					cfg_q.pattern[15:8] <= cfg_data;
				end
				CFG_PAT_16_23: begin
					cfg_q.pattern[23:16] <= cfg_data;
				end
				CFG_PAT_24_31: begin
					cfg_q.pattern[31:24] <= cfg_data;
				end
				default: begin
					// unknown index: ignored
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

[rtl/core/sflf_cmp.sv]
// ----------------------------------------------------------------------------
// sflf_cmp
// Parallel window compare: newest window byte k against pattern byte n-1-k.
// ----------------------------------------------------------------------------
module sflf_cmp #(
	parameter int PATTERN_MAX = 32
) (
	input  logic [PATTERN_MAX-1:0][7:0]            window,
	input  logic [$clog2(PATTERN_MAX+1)-1:0]       fill,
	input  logic [$clog2(PATTERN_MAX+1)-1:0]       pat_len,
	input  logic [sflf_pkg::PAT_BYTES-1:0][7:0]    pattern,
	output logic                                   hit
);
	import sflf_pkg::*;

	localparam int N_W = $clog2(PATTERN_MAX+1);

	logic [PATTERN_MAX-1:0] miss;

	always_comb begin
		logic [N_W:0] diff;
		logic [PAT_IDX_W-1:0] pidx;
		miss = '0;
		for (int k = 0; k < PATTERN_MAX; k++) begin
			diff = (N_W+1)'(pat_len) - (N_W+1)'(k) - (N_W+1)'(1);
			pidx = PAT_IDX_W'(diff);
			if ((N_W+1)'(k) < (N_W+1)'(pat_len)) begin
				miss[k] = (window[k] != pattern[pidx]);
			end
		end
	end

	// empty pattern: no byte compared, hit on every character
	assign hit = (fill >= pat_len) && !(|miss);

endmodule

[rtl/core/substring_first_last_finder.sv]
// ----------------------------------------------------------------------------
// substring_first_last_finder
// Streaming search of a configured pattern in one text line at a time.
// ----------------------------------------------------------------------------
// Usage:
//   in channel : one word per text character (text_char, line_end), taken
//                when in_valid is high and in_stall is low.
//   out channel: one result word per character (match flag, found flag,
//                leftmost/rightmost start, overflow, line end echo), taken
//                when out_valid is high and out_stall is low.
//   cfg port   : cfg_we with cfg_index/cfg_data writes a register at once;
//                write only while no word is in flight.
//   An accepted word lands in the input register; when the result register
//   is free or out_stall is low, the window compare and position update
//   are loaded into the result register. Throughput is one character per
//   cycle while out_stall is low; the window compare is combinational.
//   When out_stall is high the result holds; one more input word is still
//   taken into the input register, after that in_stall rises.
//   Reset clears the configuration, the line state and both valid flags.
//   Line state clears after the word carrying line_end.
// ----------------------------------------------------------------------------
module substring_first_last_finder #(
	parameter int PATTERN_MAX = 32,
	parameter int LINE_MAX    = 256
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  sflf_pkg::in_t                    in_data,
	output logic                             out_valid,
	input  logic                             out_stall,
	output sflf_pkg::out_t                   out_data,
	input  logic                             cfg_we,
	input  logic [sflf_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [sflf_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import sflf_pkg::*;

	localparam int N_W   = $clog2(PATTERN_MAX+1);
	localparam int POS_W = $clog2(LINE_MAX);
	localparam int CNT_W = $clog2(LINE_MAX+1);
	localparam logic [POS_W-1:0] POS_MAX = POS_W'(LINE_MAX-1);

	cfg_t cfg;

	sflf_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// pipeline control
	logic v_s1;
	in_t  in_s1;
	logic v_s2;
	out_t out_s2;
	logic adv;
	logic load;

	assign adv      = v_s1 && (!v_s2 || !out_stall);
	assign in_stall = v_s1 && !adv;
	assign load     = in_valid && !in_stall;

	// line state
	logic [PATTERN_MAX-1:0][7:0] win_q;
	logic [N_W-1:0]              fill_q;
	logic [CNT_W-1:0]            pos_q;
	logic [POS_W-1:0]            first_q;
	logic [POS_W-1:0]            last_q;
	logic                        seen_q;
	logic                        ovf_q;

	logic [PATTERN_MAX-1:0][7:0] win_new;
	logic [N_W-1:0]              fill_new;
	logic [CNT_W-1:0]            pos_new;
	logic [N_W-1:0]              pat_n;
	logic                        ovf_now;
	logic                        hit;
	logic [CNT_W:0]              start_raw;
	logic [POS_W-1:0]            start;
	logic [POS_W-1:0]            first_new;
	logic [POS_W-1:0]            last_new;
	logic                        seen_new;

	always_comb begin
		win_new[0] = in_s1.text_char;
		for (int k = 1; k < PATTERN_MAX; k++) begin
			win_new[k] = win_q[k-1];
		end
	end

	assign fill_new = (fill_q == N_W'(PATTERN_MAX)) ? fill_q : fill_q + N_W'(1);
	assign pos_new  = (pos_q == CNT_W'(LINE_MAX)) ? pos_q : pos_q + CNT_W'(1);
	assign pat_n    = (cfg.pattern_length > LEN_W'(PATTERN_MAX)) ?
	                  N_W'(PATTERN_MAX) : N_W'(cfg.pattern_length);
	assign ovf_now  = ovf_q || (pos_q == CNT_W'(LINE_MAX));

	sflf_cmp #(
		.PATTERN_MAX (PATTERN_MAX)
	) u_cmp (
		.window  (win_new),
		.fill    (fill_new),
		.pat_len (pat_n),
		.pattern (cfg.pattern),
		.hit     (hit)
	);

	// start of the occurrence ending here; wraps only when no hit is possible
	assign start_raw = {1'b0, pos_q} + (CNT_W+1)'(1) - (CNT_W+1)'(pat_n);

	always_comb begin
		if (ovf_now || start_raw > (CNT_W+1)'(LINE_MAX-1)) begin
			start = POS_MAX;
		end else begin
			start = POS_W'(start_raw);
		end
	end

	always_comb begin
		first_new = first_q;
		if (hit && !seen_q) begin
			first_new = (pat_n == '0) ? '0 : start;
		end
		last_new = hit ? start : last_q;
		seen_new = seen_q || hit;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (load) begin
				v_s1 <= 1'b1;
			end else if (adv) begin
				v_s1 <= 1'b0;
			end
			if (adv) begin
				v_s2 <= 1'b1;
			end else if (!out_stall) begin
				v_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q  <= '0;
			pos_q   <= '0;
			first_q <= '0;
			last_q  <= '0;
			seen_q  <= 1'b0;
			ovf_q   <= 1'b0;
		end else if (adv) begin
			if (in_s1.line_end) begin
				fill_q  <= '0;
				pos_q   <= '0;
				first_q <= '0;
				last_q  <= '0;
				seen_q  <= 1'b0;
				ovf_q   <= 1'b0;
			end else begin
				fill_q  <= fill_new;
				pos_q   <= pos_new;
				first_q <= first_new;
				last_q  <= last_new;
				seen_q  <= seen_new;
				ovf_q   <= ovf_now;
			end
		end
	end

	// payload registers; window entries above the fill count are never compared
	always_ff @(posedge clk) begin
		if (load) begin
			in_s1 <= in_data;
		end
		if (adv) begin
			win_q                  <= win_new;
			out_s2.match_ends_here <= hit;
			out_s2.found_any       <= seen_new;
			out_s2.leftmost_start  <= 8'(first_new);
			out_s2.rightmost_start <= 8'(last_new);
			out_s2.line_overflow   <= ovf_now;
			out_s2.is_line_end     <= in_s1.line_end;
		end
	end

	assign out_valid = v_s2;
	assign out_data  = out_s2;

endmodule

[dv/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for substring_first_last_finder. A shadow model of the
// window compare and the line position tracking predicts one result word per
// text word; a monitor pops and compares each result field by field. Directed
// cases cover empty and saturated pattern lengths, zero and all-ones bytes,
// ignored register indexes, mid-line pattern changes and long lines; random
// phases then stream lines with planted pattern copies under random idling.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import sflf_pkg::*;

	localparam int PATTERN_MAX  = 32;
	localparam int LINE_MAX     = 256;
	localparam int RANDOM_ITEMS = 700;

	logic                  clk;
	logic                  arst_n    = 1'b0;
	logic                  in_valid  = 1'b0;
	logic                  in_stall;
	in_t                   in_data   = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	out_t                  out_data;
	logic                  cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;

	// shadow configuration
	logic [LEN_W-1:0]          pat_len = '0;
	logic [PAT_BYTES-1:0][7:0] pat_mem = '0;

	// shadow line state
	logic [7:0] win [PATTERN_MAX] = '{default: '0};
	int         line_pos  = 0;
	int         win_fill  = 0;
	logic [7:0] first_pos = '0;
	logic [7:0] last_pos  = '0;
	logic       seen      = 1'b0;
	logic       line_ovf  = 1'b0;

	out_t expected_results [$];
	int   errors      = 0;
	int   items_sent  = 0;
	bit   tx_idle_on  = 1'b0;
	bit   rx_idle_on  = 1'b0;
	int   rx_hold_req = 0;
	int   rx_stall_left = 0;

	substring_first_last_finder #(
		.PATTERN_MAX(PATTERN_MAX),
		.LINE_MAX   (LINE_MAX)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	// mostly short gaps, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 40);
	endfunction

	function automatic int eff_len(input logic [LEN_W-1:0] len);
		return (len > PATTERN_MAX) ? PATTERN_MAX : int'(len);
	endfunction

	function automatic int clamp_pos(input int v);
		return (v > LINE_MAX - 1) ? LINE_MAX - 1 : v;
	endfunction

	function automatic void clear_line();
		win      = '{default: '0};
		line_pos = 0;
		win_fill = 0;
		first_pos = '0;
		last_pos = '0;
		seen     = 1'b0;
		line_ovf = 1'b0;
	endfunction

	function automatic out_t predict_result(input logic [7:0] c, input logic le);
		int   n;
		int   idx;
		int   k;
		int   start;
		logic hit;
		out_t r;
		n     = eff_len(pat_len);
		idx   = line_pos;
		hit   = 1'b0;
		start = 0;
		if (idx >= LINE_MAX)
			line_ovf = 1'b1;
		for (k = PATTERN_MAX - 1; k > 0; k--)
			win[k] = win[k-1];
		win[0] = c;
		if (win_fill < PATTERN_MAX)
			win_fill++;
		if (line_pos < LINE_MAX)
			line_pos++;
		if (n == 0) begin
			// empty pattern hits everywhere, start is just past this char
			hit   = 1'b1;
			start = line_ovf ? LINE_MAX - 1 : clamp_pos(idx + 1);
			if (!seen)
				first_pos = '0;
		end else if (win_fill >= n) begin
			hit = 1'b1;
			for (k = 0; k < n; k++)
				if (win[k] != pat_mem[n-1-k])
					hit = 1'b0;
			start = line_ovf ? LINE_MAX - 1 : clamp_pos(idx + 1 - n);
			if (hit && !seen)
				first_pos = start[7:0];
		end
		if (hit) begin
			last_pos = start[7:0];
			seen     = 1'b1;
		end
		r.match_ends_here = hit;
		r.found_any       = seen;
		r.leftmost_start  = seen ? first_pos : '0;
		r.rightmost_start = seen ? last_pos : '0;
		r.line_overflow   = line_ovf;
		r.is_line_end     = le;
		if (le)
			clear_line();
		return r;
	endfunction

	function automatic void check_field(input string name, input logic [7:0] want,
	                                    input logic [7:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, actual %0h", name, want, got);
			errors++;
		end
	endfunction

	// result monitor and receiver stall generator
	always @(posedge clk) begin
		out_t want;
		int   g;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_results.size() == 0) begin
				$error("result word with nothing expected: %h", out_data);
				errors++;
			end else begin
				want = expected_results.pop_front();
				check_field("match_ends_here", want.match_ends_here, out_data.match_ends_here);
				check_field("found_any", want.found_any, out_data.found_any);
				check_field("leftmost_start", want.leftmost_start, out_data.leftmost_start);
				check_field("rightmost_start", want.rightmost_start, out_data.rightmost_start);
				check_field("line_overflow", want.line_overflow, out_data.line_overflow);
				check_field("is_line_end", want.is_line_end, out_data.is_line_end);
			end
		end
		if (rx_hold_req > 0) begin
			rx_stall_left = rx_hold_req;
			rx_hold_req   = 0;
		end
		if (rx_stall_left > 0) begin
			rx_stall_left--;
			out_stall <= 1'b1;
		end else if (rx_idle_on) begin
			g = pick_gap();
			if (g > 0) begin
				rx_stall_left = g - 1;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end else begin
			out_stall <= 1'b0;
		end
	end

	// valid stays high between back-to-back words
	task automatic send_char(input logic [7:0] c, input logic le);
		int  gap;
		in_t w;
		gap = tx_idle_on ? pick_gap() : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		w.text_char = c;
		w.line_end  = le;
		in_valid <= 1'b1;
		in_data  <= w;
		do
			@(posedge clk);
		while (in_stall);
		expected_results.push_back(predict_result(c, le));
		items_sent++;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// leaves cfg_we high; cfg_release drops it after the last write
	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		if (idx == CFG_PAT_LEN)
			pat_len = data[LEN_W-1:0];
		else if (idx >= CFG_PAT_0_7 && idx <= CFG_PAT_24_31)
			pat_mem[int'(idx - CFG_PAT_0_7) * 8 +: 8] = data;
	endtask

	task automatic cfg_release();
		cfg_we <= 1'b0;
	endtask

	task automatic program_pattern(input logic [LEN_W-1:0] len,
	                               input logic [PAT_BYTES-1:0][7:0] p);
		logic [CFG_DATA_W-1:0] d;
		int                    g;
		d = {$urandom, $urandom};
		d[LEN_W-1:0] = len;
		cfg_write(CFG_PAT_LEN, d);
		for (g = 0; g < 4; g++)
			cfg_write(CFG_PAT_0_7 + CFG_IDX_W'(g), p[g*8 +: 8]);
		cfg_release();
	endtask

	task automatic poke_random_reg();
		cfg_write(CFG_IDX_W'($urandom_range(0, (1 << CFG_IDX_W) - 1)), {$urandom, $urandom});
		cfg_release();
	endtask

	// one line, optionally with planted pattern copies and a mid-line reg write
	task automatic send_line(input int len, input logic [7:0] sym_a, input logic [7:0] sym_b,
	                         input bit any_byte, input int plant_pct);
		logic [7:0] txt [$];
		int         n;
		int         i;
		int         j;
		int         pos;
		int         split;
		n = eff_len(pat_len);
		for (i = 0; i < len; i++)
			txt.push_back(any_byte ? 8'($urandom_range(0, 255))
			                       : ($urandom_range(0, 1) ? sym_a : sym_b));
		if (n > 0 && n <= len && $urandom_range(0, 99) < plant_pct) begin
			repeat ($urandom_range(1, 3)) begin
				pos = $urandom_range(0, len - n);
				for (j = 0; j < n; j++)
					txt[pos+j] = pat_mem[j];
			end
		end
		split = (len > 1 && $urandom_range(0, 15) == 0) ? $urandom_range(1, len - 1) : 0;
		for (i = 0; i < len; i++) begin
			if (split > 0 && i == split) begin
				drain();
				poke_random_reg();
			end
			send_char(txt[i], i == len - 1);
		end
	endtask

	task automatic test_empty_default();
		send_char(8'h00, 1'b0);
		send_char(8'hFF, 1'b0);
		send_char(8'h5A, 1'b1);
		drain();
	endtask

	task automatic test_ignored_index();
		int u;
		for (u = int'(CFG_PAT_24_31) + 1; u < (1 << CFG_IDX_W); u++)
			cfg_write(CFG_IDX_W'(u), '1);
		cfg_release();
		send_char(8'hA5, 1'b0);
		send_char(8'h3C, 1'b1);
		drain();
	endtask

	task automatic test_zero_and_ones();
		logic [PAT_BYTES-1:0][7:0] p;
		p    = '1;
		p[0] = 8'h00;
		program_pattern(6'd2, p);
		send_char(8'h00, 1'b0);
		send_char(8'hFF, 1'b0);
		send_char(8'h00, 1'b0);
		send_char(8'hFF, 1'b1);
		send_char(8'hFF, 1'b0);
		send_char(8'h00, 1'b1);
		drain();
		program_pattern(6'd1, '0);
		send_char(8'h00, 1'b1);
		drain();
	endtask

	task automatic test_length_saturation();
		logic [PAT_BYTES-1:0][7:0] p;
		int                        i;
		for (i = 0; i < PAT_BYTES; i++)
			p[i] = 8'($urandom);
		program_pattern('1, p);
		for (i = 0; i < PAT_BYTES; i++)
			send_char(p[i], 1'b0);
		send_char(8'($urandom), 1'b1);
		drain();
	endtask

	task automatic test_midline_config();
		logic [PAT_BYTES-1:0][7:0] p;
		logic [7:0]                a;
		a    = 8'($urandom);
		p    = '0;
		p[0] = a;
		program_pattern(6'd1, p);
		send_char(a, 1'b0);
		send_char(~a, 1'b0);
		drain();
		p[0] = ~a;
		cfg_write(CFG_PAT_0_7, p[7:0]);
		cfg_release();
		send_char(~a, 1'b1);
		drain();
	endtask

	task automatic test_long_line();
		logic [PAT_BYTES-1:0][7:0] p;
		logic [7:0]                a;
		logic [7:0]                b;
		int                        i;
		a    = 8'($urandom);
		b    = 8'($urandom);
		p    = '0;
		p[0] = a;
		p[1] = b;
		program_pattern(6'd2, p);
		for (i = 0; i < 270; i++)
			send_char($urandom_range(0, 1) ? a : b, i == 269);
		drain();
		program_pattern(6'd0, p);
		for (i = 0; i < 258; i++)
			send_char(8'($urandom), i == 257);
		drain();
	endtask

	task automatic test_backpressure();
		logic [PAT_BYTES-1:0][7:0] p;
		logic [7:0]                a;
		int                        i;
		a    = 8'($urandom);
		p    = '0;
		p[0] = a;
		program_pattern(6'd1, p);
		tx_idle_on  = 1'b0;
		rx_idle_on  = 1'b0;
		rx_hold_req = 60;
		for (i = 0; i < 30; i++)
			send_char($urandom_range(0, 1) ? a : ~a, i == 29);
		// sender waits here for every result
		drain();
		tx_idle_on  = 1'b1;
		rx_hold_req = 40;
		for (i = 0; i < 20; i++)
			send_char($urandom_range(0, 1) ? a : ~a, i == 19);
		drain();
	endtask

	task automatic test_random_lines();
		logic [PAT_BYTES-1:0][7:0] p;
		logic [7:0]                a;
		logic [7:0]                b;
		bit                        any_byte;
		int                        base;
		int                        r;
		int                        k;
		int                        n;
		int                        len;
		logic [LEN_W-1:0]          len_cfg;
		base = items_sent;
		while (items_sent - base < RANDOM_ITEMS) begin
			drain();
			if ($urandom_range(0, 9) == 0) begin
				a = 8'h00;
				b = 8'hFF;
			end else begin
				a = 8'($urandom);
				b = 8'($urandom);
			end
			any_byte = ($urandom_range(0, 4) == 0);
			for (k = 0; k < PAT_BYTES; k++)
				p[k] = any_byte ? 8'($urandom) : ($urandom_range(0, 1) ? a : b);
			r = $urandom_range(0, 99);
			if (r < 8)
				len_cfg = '0;
			else if (r < 55)
				len_cfg = LEN_W'($urandom_range(1, 3));
			else if (r < 80)
				len_cfg = LEN_W'($urandom_range(4, 8));
			else if (r < 90)
				len_cfg = LEN_W'($urandom_range(9, 31));
			else if (r < 95)
				len_cfg = LEN_W'(PATTERN_MAX);
			else
				len_cfg = LEN_W'($urandom_range(PATTERN_MAX + 1, (1 << LEN_W) - 1));
			program_pattern(len_cfg, p);
			tx_idle_on = ($urandom_range(0, 3) != 0);
			rx_idle_on = ($urandom_range(0, 3) != 0);
			n = eff_len(len_cfg);
			repeat ($urandom_range(3, 8)) begin
				r = $urandom_range(0, 99);
				if (r < 85)
					len = $urandom_range(1, 24);
				else if (r < 99)
					len = $urandom_range(25, 70);
				else
					len = $urandom_range(250, 300);
				if (len < n)
					len = n + $urandom_range(0, 8);
				send_line(len, a, b, any_byte, 70);
			end
		end
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;
		test_empty_default();
		test_ignored_index();
		test_zero_and_ones();
		test_length_saturation();
		test_midline_config();
		test_long_line();
		test_backpressure();
		test_random_lines();
		drain();
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
